### design/acew_pkg.sv
// Shared widths, the queued triangle word and index helpers for the
// absolute cotangent edge weight core. No dependencies.
`timescale 1ns / 1ps

package acew_pkg;

	localparam int IDX_W       = 16;
	localparam int CRD_W       = 24;
	localparam int EDGE_W      = CRD_W + 1;
	localparam int PROD_W      = 2 * EDGE_W;
	localparam int MAG_W       = 50;
	localparam int S_W         = 2 * MAG_W;
	localparam int W_W         = 32;
	localparam int Q_W         = 2 * W_W;
	localparam int SR_W        = W_W + 4;
	localparam int QUEUE_DEPTH = 4;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [MAG_W-1:0] mag_t;

	// one classified triangle: indices, cross magnitudes, dot magnitudes
	typedef struct packed {
		idx_t            idx_a;
		idx_t            idx_b;
		idx_t            idx_c;
		logic [2:0][MAG_W-1:0] cm;
		logic [2:0][MAG_W-1:0] dm;
	} tri_t;

	// vertex index of corner n
	function automatic idx_t corner_idx(tri_t t, logic [1:0] n);
		idx_t r;
		r = t.idx_c;
		unique case (n)
			2'd0:    r = t.idx_a;
			2'd1:    r = t.idx_b;
			default: r = t.idx_c;
		endcase
		return r;
	endfunction

	// corner that precedes corner n, (n + 2) mod 3
	function automatic logic [1:0] prev_corner(logic [1:0] n);
		logic [1:0] r;
		r = 2'd1;
		unique case (n)
			2'd0:    r = 2'd2;
			2'd1:    r = 2'd0;
			default: r = 2'd1;
		endcase
		return r;
	endfunction

endpackage

### design/acew_front.sv
// Front end: takes a triangle word, forms edges, cross and dot products
// and their magnitudes in three stages. Depends on acew_pkg.
`timescale 1ns / 1ps

module acew_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             take,
	input  acew_pkg::idx_t                   index_a,
	input  acew_pkg::idx_t                   index_b,
	input  acew_pkg::idx_t                   index_c,
	input  logic signed [acew_pkg::CRD_W-1:0] ax,
	input  logic signed [acew_pkg::CRD_W-1:0] ay,
	input  logic signed [acew_pkg::CRD_W-1:0] az,
	input  logic signed [acew_pkg::CRD_W-1:0] bx,
	input  logic signed [acew_pkg::CRD_W-1:0] by,
	input  logic signed [acew_pkg::CRD_W-1:0] bz,
	input  logic signed [acew_pkg::CRD_W-1:0] cx,
	input  logic signed [acew_pkg::CRD_W-1:0] cy,
	input  logic signed [acew_pkg::CRD_W-1:0] cz,
	output logic                             push,
	output acew_pkg::tri_t                   word,
	output logic [1:0]                       inflight
);

	localparam int EW = acew_pkg::EDGE_W;
	localparam int PW = acew_pkg::PROD_W;
	localparam int MW = acew_pkg::MAG_W;

	logic v_s1, v_s2, v_s3;
	acew_pkg::idx_t idx_s1 [3];
	acew_pkg::idx_t idx_s2 [3];
	logic signed [EW-1:0] e_s1 [3][3];
	logic signed [PW-1:0] cp_s2 [6];
	logic signed [PW-1:0] dp_s2 [3][3];
	logic signed [PW:0]   cr_c [3];
	logic signed [PW+1:0] dt_c [3];
	acew_pkg::tri_t word_c;
	acew_pkg::tri_t word_s3;

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: edge vectors e0 = b - a, e1 = c - b, e2 = a - c
	always_ff @(posedge clk) begin
		idx_s1[0] <= index_a;
		idx_s1[1] <= index_b;
		idx_s1[2] <= index_c;
		e_s1[0][0] <= $signed({bx[EW-2], bx}) - $signed({ax[EW-2], ax});
		e_s1[0][1] <= $signed({by[EW-2], by}) - $signed({ay[EW-2], ay});
		e_s1[0][2] <= $signed({bz[EW-2], bz}) - $signed({az[EW-2], az});
		e_s1[1][0] <= $signed({cx[EW-2], cx}) - $signed({bx[EW-2], bx});
		e_s1[1][1] <= $signed({cy[EW-2], cy}) - $signed({by[EW-2], by});
		e_s1[1][2] <= $signed({cz[EW-2], cz}) - $signed({bz[EW-2], bz});
		e_s1[2][0] <= $signed({ax[EW-2], ax}) - $signed({cx[EW-2], cx});
		e_s1[2][1] <= $signed({ay[EW-2], ay}) - $signed({cy[EW-2], cy});
		e_s1[2][2] <= $signed({az[EW-2], az}) - $signed({cz[EW-2], cz});
	end

	// stage 2: cross terms of e0 x e1 and dot terms of each corner
	always_ff @(posedge clk) begin
		idx_s2 <= idx_s1;
		cp_s2[0] <= e_s1[0][1] * e_s1[1][2];
		cp_s2[1] <= e_s1[0][2] * e_s1[1][1];
		cp_s2[2] <= e_s1[0][2] * e_s1[1][0];
		cp_s2[3] <= e_s1[0][0] * e_s1[1][2];
		cp_s2[4] <= e_s1[0][0] * e_s1[1][1];
		cp_s2[5] <= e_s1[0][1] * e_s1[1][0];
		for (int j = 0; j < 3; j++) begin
			for (int n = 0; n < 3; n++) begin
				dp_s2[j][n] <= e_s1[j][n] * e_s1[(j + 1) % 3][n];
			end
		end
	end

	// stage 3: sum the terms and drop the signs
	always_comb begin
		for (int n = 0; n < 3; n++) begin
			cr_c[n] = {cp_s2[2*n][PW-1], cp_s2[2*n]}
				- {cp_s2[2*n+1][PW-1], cp_s2[2*n+1]};
			dt_c[n] = {{2{dp_s2[n][0][PW-1]}}, dp_s2[n][0]}
				+ {{2{dp_s2[n][1][PW-1]}}, dp_s2[n][1]}
				+ {{2{dp_s2[n][2][PW-1]}}, dp_s2[n][2]};
		end
		word_c.idx_a = idx_s2[0];
		word_c.idx_b = idx_s2[1];
		word_c.idx_c = idx_s2[2];
		for (int n = 0; n < 3; n++) begin
			word_c.cm[n] = cr_c[n][PW] ? MW'(-cr_c[n]) : MW'(cr_c[n]);
			word_c.dm[n] = dt_c[n][PW+1] ? MW'(-dt_c[n]) : MW'(dt_c[n]);
		end
	end

	always_ff @(posedge clk) begin
		word_s3 <= word_c;
	end

	assign push     = v_s3;
	assign word     = word_s3;
	assign inflight = {1'b0, v_s1} + {1'b0, v_s2} + {1'b0, v_s3};

endmodule

### design/acew_queue.sv
// Short queue of classified triangle words between front and back.
// Depends on acew_pkg.
`timescale 1ns / 1ps

module acew_queue #(
	parameter int DEPTH = acew_pkg::QUEUE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  acew_pkg::tri_t               wdata,
	input  logic                         pop,
	output acew_pkg::tri_t               rdata,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	acew_pkg::tri_t    mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// hold words
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	assign rdata = mem_q[rd_ptr_q];
	assign count = count_q;

endmodule

### design/acew_back.sv
// Back end: area square sum, per-corner dot square, long division and
// square root, then two result words per corner. Depends on acew_pkg.
`timescale 1ns / 1ps

module acew_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  acew_pkg::tri_t                head,
	output logic                          pop,
	output logic                          strobe,
	output acew_pkg::idx_t                row_index,
	output acew_pkg::idx_t                col_index,
	output logic [acew_pkg::W_W-1:0]      weight,
	output logic                          degenerate,
	output logic                          last
);

	localparam int MW    = acew_pkg::MAG_W;
	localparam int SW    = acew_pkg::S_W;
	localparam int WW    = acew_pkg::W_W;
	localparam int QW    = acew_pkg::Q_W;
	localparam int RW    = acew_pkg::SR_W;
	localparam int CNT_W = $clog2(QW + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_SQ, ST_CHK, ST_DSQ, ST_DIV0, ST_DIV, ST_SQRT, ST_EMIT_A
	} state_t;

	// which word of the corner pair goes out next
	typedef enum logic {PH_A, PH_B} phase_t;

	state_t              st_q;
	phase_t              ph_q;
	acew_pkg::tri_t      tri_q;
	logic [1:0]          pass_q, corner_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [SW-1:0]       s_q, d2_q, mcand_q, rem_q;
	logic [MW-1:0]       mplier_q;
	logic [QW-1:0]       xlo_q, quo_q;
	logic [RW-1:0]       srem_q;
	logic [WW-1:0]       root_q, wcalc_q;
	logic                degen_q;
	logic                strobe_q, degen_out_q, last_q;
	acew_pkg::idx_t      row_q, col_q;
	logic [WW-1:0]       wout_q;

	logic [SW-1:0]       acc_sum, d2_hi;
	logic [SW:0]         div_trial, div_diff;
	logic                div_ge;
	logic [RW-1:0]       sq_t, sq_trial;
	logic                sq_ge;
	logic [WW-1:0]       root_nx;
	logic [1:0]          prev_c, next_c;

	// shift-add step, division step and root step
	always_comb begin
		acc_sum   = ((st_q == ST_SQ) ? s_q : d2_q) + mcand_q;
		d2_hi     = d2_q >> WW;
		div_trial = {rem_q, xlo_q[QW-1]};
		div_diff  = div_trial - {1'b0, s_q};
		div_ge    = div_trial >= {1'b0, s_q};
		sq_t      = {srem_q[RW-3:0], quo_q[QW-1:QW-2]};
		sq_trial  = RW'({root_q, 2'b01});
		sq_ge     = sq_t >= sq_trial;
		root_nx   = {root_q[WW-2:0], sq_ge};
		prev_c    = acew_pkg::prev_corner(corner_q);
		next_c    = corner_q + 2'd1;
	end

	assign pop = (st_q == ST_IDLE) && q_valid;

	// sequence one triangle and register the result words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			ph_q        <= PH_A;
			tri_q       <= '0;
			pass_q      <= '0;
			corner_q    <= '0;
			cnt_q       <= '0;
			s_q         <= '0;
			d2_q        <= '0;
			mcand_q     <= '0;
			rem_q       <= '0;
			mplier_q    <= '0;
			xlo_q       <= '0;
			quo_q       <= '0;
			srem_q      <= '0;
			root_q      <= '0;
			wcalc_q     <= '0;
			degen_q     <= 1'b0;
			strobe_q    <= 1'b0;
			degen_out_q <= 1'b0;
			last_q      <= 1'b0;
			row_q       <= '0;
			col_q       <= '0;
			wout_q      <= '0;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (q_valid) begin
						tri_q    <= head;
						s_q      <= '0;
						pass_q   <= 2'd0;
						mcand_q  <= SW'(head.cm[0]);
						mplier_q <= head.cm[0];
						cnt_q    <= CNT_W'(MW);
						st_q     <= ST_SQ;
					end
				end
				ST_SQ: begin
					if (mplier_q[0]) begin
						s_q <= acc_sum;
					end
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					cnt_q    <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						if (pass_q == 2'd2) begin
							st_q <= ST_CHK;
						end else begin
							pass_q   <= pass_q + 2'd1;
							mcand_q  <= SW'(tri_q.cm[pass_q + 2'd1]);
							mplier_q <= tri_q.cm[pass_q + 2'd1];
							cnt_q    <= CNT_W'(MW);
						end
					end
				end
				ST_CHK: begin
					corner_q <= 2'd0;
					degen_q  <= (s_q == '0);
					ph_q     <= PH_A;
					if (s_q == '0) begin
						wcalc_q <= '1;
						st_q    <= ST_EMIT_A;
					end else begin
						d2_q     <= '0;
						mcand_q  <= SW'(tri_q.dm[0]);
						mplier_q <= tri_q.dm[0];
						cnt_q    <= CNT_W'(MW);
						st_q     <= ST_DSQ;
					end
				end
				ST_DSQ: begin
					if (mplier_q[0]) begin
						d2_q <= acc_sum;
					end
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					cnt_q    <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						st_q <= ST_DIV0;
					end
				end
				ST_DIV0: begin
					// quotient of 2^64 or more saturates the weight
					if (d2_hi >= s_q) begin
						wcalc_q <= '1;
						st_q    <= ST_EMIT_A;
					end else begin
						rem_q <= d2_hi;
						xlo_q <= {d2_q[WW-1:0], WW'(0)};
						quo_q <= '0;
						cnt_q <= CNT_W'(QW);
						st_q  <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= div_ge ? div_diff[SW-1:0] : div_trial[SW-1:0];
					quo_q <= {quo_q[QW-2:0], div_ge};
					xlo_q <= xlo_q << 1;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						srem_q <= '0;
						root_q <= '0;
						cnt_q  <= CNT_W'(WW);
						st_q   <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					srem_q <= sq_ge ? (sq_t - sq_trial) : sq_t;
					root_q <= root_nx;
					quo_q  <= quo_q << 2;
					cnt_q  <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						wcalc_q <= root_nx;
						ph_q    <= PH_A;
						st_q    <= ST_EMIT_A;
					end
				end
				ST_EMIT_A: begin
					strobe_q    <= 1'b1;
					wout_q      <= wcalc_q;
					degen_out_q <= degen_q;
					if (ph_q == PH_A) begin
						row_q <= acew_pkg::corner_idx(tri_q, prev_c);
						col_q <= acew_pkg::corner_idx(tri_q, corner_q);
						ph_q  <= PH_B;
					end else begin
						row_q  <= acew_pkg::corner_idx(tri_q, corner_q);
						col_q  <= acew_pkg::corner_idx(tri_q, prev_c);
						last_q <= (corner_q == 2'd2);
						ph_q   <= PH_A;
						if (corner_q == 2'd2) begin
							st_q <= ST_IDLE;
						end else begin
							corner_q <= next_c;
							if (!degen_q) begin
								d2_q     <= '0;
								mcand_q  <= SW'(tri_q.dm[next_c]);
								mplier_q <= tri_q.dm[next_c];
								cnt_q    <= CNT_W'(MW);
								st_q     <= ST_DSQ;
							end
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign strobe     = strobe_q;
	assign row_index  = row_q;
	assign col_index  = col_q;
	assign weight     = wout_q;
	assign degenerate = degen_out_q;
	assign last       = last_q;

endmodule

### design/abs_cotangent_edge_weights_core.sv
// Top level of the absolute cotangent edge weight core: front end, queue
// and back end. Depends on acew_pkg, acew_front, acew_queue, acew_back.
//
//  channel   handshake                   word
//  input     start in, busy out          index_a..c, ax..cz
//  result    strobe out (no stall)       row_index, col_index, weight,
//                                        degenerate, last
//
// A triangle passes through the front stages, then waits in the queue.
// The back end takes one triangle at a time from the queue: a 50-step shift-add
// square for each cross term and each dot term, a 64-step division and a
// 32-step square root per corner; zero area leaves only the cross squares.
// busy rises when the front stages and queue together hold QUEUE_DEPTH words.
// Reset clears all control state; no clearing pass is needed.
// The receiver cannot stall: each result word shows for one strobe cycle.
`timescale 1ns / 1ps

module abs_cotangent_edge_weights_core #(
	parameter int QUEUE_DEPTH = acew_pkg::QUEUE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  acew_pkg::idx_t                    index_a,
	input  acew_pkg::idx_t                    index_b,
	input  acew_pkg::idx_t                    index_c,
	input  logic signed [acew_pkg::CRD_W-1:0] ax,
	input  logic signed [acew_pkg::CRD_W-1:0] ay,
	input  logic signed [acew_pkg::CRD_W-1:0] az,
	input  logic signed [acew_pkg::CRD_W-1:0] bx,
	input  logic signed [acew_pkg::CRD_W-1:0] by,
	input  logic signed [acew_pkg::CRD_W-1:0] bz,
	input  logic signed [acew_pkg::CRD_W-1:0] cx,
	input  logic signed [acew_pkg::CRD_W-1:0] cy,
	input  logic signed [acew_pkg::CRD_W-1:0] cz,
	output logic                              strobe,
	output acew_pkg::idx_t                    row_index,
	output acew_pkg::idx_t                    col_index,
	output logic [acew_pkg::W_W-1:0]          weight,
	output logic                              degenerate,
	output logic                              last
);

	localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

	logic                take, push, pop, q_valid;
	logic [1:0]          inflight;
	logic [QC_W-1:0]     q_count;
	logic [QC_W:0]       load;
	acew_pkg::tri_t      f_word, q_head;

	// hold off new words when the queue could overflow
	assign load    = (QC_W + 1)'(q_count) + (QC_W + 1)'(inflight);
	assign busy    = load >= (QC_W + 1)'(QUEUE_DEPTH);
	assign take    = start && !busy;
	assign q_valid = (q_count != '0);

	acew_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.index_a  (index_a),
		.index_b  (index_b),
		.index_c  (index_c),
		.ax       (ax),
		.ay       (ay),
		.az       (az),
		.bx       (bx),
		.by       (by),
		.bz       (bz),
		.cx       (cx),
		.cy       (cy),
		.cz       (cz),
		.push     (push),
		.word     (f_word),
		.inflight (inflight)
	);

	acew_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (f_word),
		.pop    (pop),
		.rdata  (q_head),
		.count  (q_count)
	);

	acew_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.head       (q_head),
		.pop        (pop),
		.strobe     (strobe),
		.row_index  (row_index),
		.col_index  (col_index),
		.weight     (weight),
		.degenerate (degenerate),
		.last       (last)
	);

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (q_count != '0))
		else $error("pop from empty queue");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (q_count != QC_W'(QUEUE_DEPTH)))
		else $error("push into full queue");

	a_last_strobed: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> (strobe && $past(strobe)))
		else $error("last word without its pair");

endmodule

### test/abs_cotangent_edge_weights_core_tb.sv
// Self-checking bench for abs_cotangent_edge_weights_core: directed and random triangles,
// six predicted weight words each, checked in order. Depends on acew_pkg and the core.
`timescale 1ns / 1ps

module abs_cotangent_edge_weights_core_tb;

	typedef acew_pkg::idx_t idx_t;

	typedef struct {
		idx_t             ia, ib, ic;
		logic [8:0][23:0] p;        // ax ay az bx by bz cx cy cz
		bit               drain_first;
	} triangle_t;

	typedef struct {
		idx_t        row, col;
		logic [31:0] w;
		logic        dg, lst;
	} weight_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	idx_t index_a = '0, index_b = '0, index_c = '0;
	logic signed [23:0] ax = '0, ay = '0, az = '0, bx = '0, by = '0, bz = '0;
	logic signed [23:0] cx = '0, cy = '0, cz = '0;
	logic strobe;
	idx_t row_index, col_index;
	logic [31:0] weight;
	logic degenerate, last;

	triangle_t    pending_tris[$];
	weight_word_t expected_words[$];
	triangle_t    cur_tri;
	int           gap_left = 0;
	int           mismatches = 0;
	bit           stim_done = 1'b0;

	abs_cotangent_edge_weights_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.index_a(index_a), .index_b(index_b), .index_c(index_c),
		.ax(ax), .ay(ay), .az(az), .bx(bx), .by(by), .bz(bz),
		.cx(cx), .cy(cy), .cz(cz),
		.strobe(strobe), .row_index(row_index), .col_index(col_index),
		.weight(weight), .degenerate(degenerate), .last(last)
	);

	always #1 clk = ~clk;

	// floor(d * 2^16 / sqrt(s)) by bitwise search, clipped to 32 bits
	function automatic logic [31:0] cot_q16(longint unsigned d, logic [127:0] s);
		logic [191:0] rhs, lhs;
		logic [31:0]  w, c;
		rhs = (192'(d) * 192'(d)) << 32;
		w = '0;
		for (int b = 31; b >= 0; b--) begin
			c = w | (32'd1 << b);
			lhs = 192'(c) * 192'(c) * 192'(s);
			if (lhs <= rhs)
				w = c;
		end
		return w;
	endfunction

	// queue the six weight words of one triangle
	task automatic predict_weights(triangle_t t);
		longint          pt[3][3], e[3][3], cr[3], dot;
		longint unsigned m;
		logic [127:0]    s;
		logic [31:0]     w;
		bit              dg;
		idx_t            ids[3];
		int              i, k, r;
		weight_word_t    ww;
		ids[0] = t.ia; ids[1] = t.ib; ids[2] = t.ic;
		for (int j = 0; j < 3; j++)
			for (int n = 0; n < 3; n++)
				pt[j][n] = longint'($signed(t.p[j*3+n]));
		for (int j = 0; j < 3; j++)
			for (int n = 0; n < 3; n++)
				e[j][n] = pt[(j+1)%3][n] - pt[j][n];
		cr[0] = e[0][1] * e[1][2] - e[0][2] * e[1][1];
		cr[1] = e[0][2] * e[1][0] - e[0][0] * e[1][2];
		cr[2] = e[0][0] * e[1][1] - e[0][1] * e[1][0];
		s = '0;
		for (int n = 0; n < 3; n++) begin
			m = cr[n] < 0 ? -cr[n] : cr[n];
			s += 128'(m) * 128'(m);
		end
		dg = (s == '0);
		r = 0;
		for (int j = 0; j < 3; j++) begin
			k = (j + 1) % 3;
			i = (j + 2) % 3;
			dot = e[j][0] * e[k][0] + e[j][1] * e[k][1] + e[j][2] * e[k][2];
			w = dg ? 32'hFFFF_FFFF : cot_q16(dot < 0 ? -dot : dot, s);
			for (int h = 0; h < 2; h++) begin
				ww.row = h == 0 ? ids[i] : ids[j];
				ww.col = h == 0 ? ids[j] : ids[i];
				ww.w   = w;
				ww.dg  = dg;
				ww.lst = (r == 5);
				expected_words.push_back(ww);
				r++;
			end
		end
	endtask

	// driver: retire the accepted word, then hold, idle or launch the next
	always @(posedge clk) begin
		triangle_t t;
		bit        active;
		active = start;
		if (start && !busy) begin
			predict_weights(cur_tri);
			active = 1'b0;
		end
		if (!active && arst_n) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
			end else if (pending_tris.size() > 0 &&
					!(pending_tris[0].drain_first && expected_words.size() > 0)) begin
				t = pending_tris.pop_front();
				cur_tri <= t;
				index_a <= t.ia; index_b <= t.ib; index_c <= t.ic;
				ax <= t.p[0]; ay <= t.p[1]; az <= t.p[2];
				bx <= t.p[3]; by <= t.p[4]; bz <= t.p[5];
				cx <= t.p[6]; cy <= t.p[7]; cz <= t.p[8];
				active = 1'b1;
				case ($urandom_range(9, 0))
					0:       gap_left <= $urandom_range(900, 30);
					1, 2, 3: gap_left <= $urandom_range(4, 1);
					default: gap_left <= 0;
				endcase
			end
		end
		start <= active;
	end

	// monitor: compare each strobed word with the oldest expectation
	always @(posedge clk) begin
		weight_word_t ex;
		if (arst_n && strobe) begin
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: row %h col %h weight %h", row_index,
						col_index, weight);
			end else begin
				ex = expected_words.pop_front();
				if (row_index !== ex.row || col_index !== ex.col || weight !== ex.w ||
						degenerate !== ex.dg || last !== ex.lst) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp row %h col %h w %h dg %b last %b, got %h %h %h %b %b",
							ex.row, ex.col, ex.w, ex.dg, ex.lst,
							row_index, col_index, weight, degenerate, last);
				end
			end
		end
	end

	function automatic logic [23:0] rnd_coord(int mode);
		case (mode)
			0:       return 24'($urandom);
			1:       return 24'($signed($urandom_range(8192, 0)) - 4096);
			default: return 24'($signed($urandom_range(64, 0)) - 32);
		endcase
	endfunction

	function automatic triangle_t make_tri(idx_t a, idx_t b, idx_t c,
			logic [8:0][23:0] p, bit drain);
		triangle_t t;
		t.ia = a; t.ib = b; t.ic = c; t.p = p; t.drain_first = drain;
		return t;
	endfunction

	// stimulus: directed corner cases, then random triangles
	initial begin
		logic [8:0][23:0] p;
		int mode, k;
		// all corners at origin: zero area
		pending_tris.push_back(make_tri(16'h0000, 16'hFFFF, 16'h1234, '0, 1'b0));
		// right angle at a: one weight zero
		p = '0; p[3] = 24'd4096; p[7] = 24'd4096;
		pending_tris.push_back(make_tri(16'hFFFF, 16'h0000, 16'h0001, p, 1'b0));
		// coordinate extremes
		p = {9{24'h7FFFFF}}; p[3] = 24'h800000; p[7] = 24'h800000; p[8] = 24'h800000;
		pending_tris.push_back(make_tri(16'h0001, 16'h0002, 16'h0003, p, 1'b0));
		p = {9{24'h800000}}; p[0] = 24'h7FFFFF; p[4] = 24'h7FFFFF; p[8] = 24'h7FFFFF;
		pending_tris.push_back(make_tri(16'hAAAA, 16'h5555, 16'hFFFF, p, 1'b0));
		// collinear points: zero area with nonzero dot products
		p = '0; p[3] = 24'd100; p[4] = 24'd200; p[6] = 24'd300; p[7] = 24'd600;
		pending_tris.push_back(make_tri(16'd7, 16'd8, 16'd9, p, 1'b0));
		// two corners coincide
		p = '0; p[0] = 24'd5; p[3] = 24'd5; p[8] = 24'd77;
		pending_tris.push_back(make_tri(16'd10, 16'd11, 16'd12, p, 1'b0));
		// sliver: cotangent beyond Q16.16 range saturates without degenerate
		p = '0; p[3] = 24'h7FFFFF; p[6] = 24'h400000; p[7] = 24'd1;
		pending_tris.push_back(make_tri(16'd13, 16'd14, 16'd15, p, 1'b0));
		// same indices on all corners, small equilateral-like triangle
		p = '0; p[3] = 24'd2; p[6] = 24'd1; p[7] = 24'd2;
		pending_tris.push_back(make_tri(16'h8000, 16'h8000, 16'h8000, p, 1'b1));
		for (int n = 0; n < 480; n++) begin
			mode = $urandom_range(2, 0);
			for (int q = 0; q < 9; q++)
				p[q] = rnd_coord(mode);
			k = $urandom_range(19, 0);
			if (k == 0) begin
				// collinear: c = a + 2(b - a)
				for (int q = 0; q < 3; q++)
					p[6+q] = 24'($signed(p[q]) + 2 * ($signed(p[3+q]) - $signed(p[q])));
			end else if (k == 1) begin
				p[5:3] = p[2:0];
			end else if (k == 2) begin
				// thin triangle: c barely off the segment ab
				for (int q = 0; q < 3; q++)
					p[6+q] = p[q];
				p[6] = p[6] + 24'd1;
			end
			pending_tris.push_back(make_tri(idx_t'($urandom), idx_t'($urandom),
				idx_t'($urandom), p, (n % 97) == 50));
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_tris.size() == 0 && !start);
		wait (expected_words.size() == 0);
		repeat (700) @(posedge clk);
		if (mismatches == 0 && expected_words.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// end the run with an error if it has not finished by the time limit
	initial begin
		#8_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
